[design/srea_pkg.sv]
// srea_pkg: shared types and constants of the sparse row embedding aggregate
// command codes, register indexes, request and result records
// no dependencies
package srea_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_SPARSE  = 2'd1;
  localparam logic [1:0] CMD_ROW_END = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [1:0] CFG_MEAN_MODE  = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_DIM = 2'd1;

  localparam int ACC_W  = 40;
  localparam int WT_W   = 28;
  localparam int PROD_W = 32;
  localparam int DIV_W  = 42;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         node_index;
    logic [5:0]         element_index;
    logic signed [15:0] table_value;
    logic signed [15:0] edge_weight;
  } item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [5:0]         element;
    logic               last_element;
    logic               zero_weight_sum;
    logic               saturated;
  } result_t;

endpackage

[design/srea_front.sv]
// srea_front: request intake, drops unused commands and queues the rest
// a short queue decouples intake from the execution engine
// depends on srea_pkg
module srea_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  srea_pkg::item_t in_item,
  output logic           q_empty,
  input  logic           q_pop,
  output srea_pkg::item_t q_head
);
  import srea_pkg::*;

  item_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                wr, rd;

  assign in_full = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rp_r];
  // command three is taken and then forgotten
  assign wr = in_push && !in_full && (in_item.command != CMD_UNUSED);
  assign rd = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      if (wr && !rd) cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[design/srea_ofifo.sv]
// srea_ofifo: two-entry result queue towards the consumer
// lets the engine keep working while a result waits to be taken
// depends on srea_pkg
module srea_ofifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  srea_pkg::result_t din,
  output logic             empty,
  input  logic             pop,
  output srea_pkg::result_t dout
);
  import srea_pkg::*;

  result_t     mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr, rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      if (wr && !rd) cnt_r <= cnt_r + 2'd1;
      else if (rd && !wr) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

[design/srea_back.sv]
// srea_back: execution engine, table memory, accumulator memory, divider
// runs loads, sparse entries (three-stage multiply-accumulate) and row ends
// depends on srea_pkg
module srea_back #(
  parameter int TABLE_ROWS = 1024,
  parameter int EMBED_DIM  = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  srea_pkg::item_t   q_head,
  output logic              q_pop,
  input  logic              mean_mode,
  input  logic [6:0]        active_dim,
  input  logic              o_full,
  output logic              o_push,
  output srea_pkg::result_t o_data
);
  import srea_pkg::*;

  localparam int EW = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int TDEPTH = TABLE_ROWS * EMBED_DIM;
  localparam int AW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam logic [ACC_W:0] RND = (ACC_W+1)'(2 ** FRAC_BITS / 2);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SPARSE = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_RD     = 7'b0001000,
    S_CALC   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [EW-1:0] d_r, d_nxt, dim_last, p1_d_r, p2_d_r;
  logic          p1_v_r, p2_v_r;
  logic [9:0]    node_r, node_nxt;
  logic signed [15:0] wgt_r, wgt_nxt;
  logic signed [15:0] tbl_mem [TDEPTH];
  logic signed [15:0] tbl_q_r;
  logic signed [ACC_W-1:0] acc_mem [EMBED_DIM];
  logic signed [ACC_W-1:0] acc_q_r, accb_r, acc_cur;
  logic          accv_q_r;
  logic [EMBED_DIM-1:0] vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W:0] acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [WT_W-1:0] wt_r;
  logic signed [WT_W:0] wt_sum;
  logic signed [WT_W-1:0] wt_sat;
  logic [DIV_W-1:0] n_r, n_nxt, q_r, q_nxt;
  logic [WT_W:0]    den_r, den_nxt, rem_r, rem_nxt;
  logic [WT_W+1:0]  trial;
  logic             ge;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt, zf_r, zf_nxt;
  logic [ACC_W-1:0] mag;
  logic [WT_W-1:0]  wm;
  logic             tbl_we, in_range_ld, in_range_sp, last, sat;
  logic [AW-1:0]    tbl_waddr, tbl_raddr;
  logic signed [15:0] value;

  always_comb begin
    priority if (active_dim == 7'd0) dim_last = '0;
    else if (32'(active_dim) > EMBED_DIM) dim_last = EW'(EMBED_DIM - 1);
    else dim_last = EW'(active_dim - 7'd1);
  end

  assign in_range_ld = (32'(q_head.node_index) < TABLE_ROWS) &&
                       (32'(q_head.element_index) < EMBED_DIM);
  assign in_range_sp = (32'(q_head.node_index) < TABLE_ROWS);
  assign q_pop  = (state_r == S_IDLE) && !q_empty;
  assign tbl_we = q_pop && (q_head.command == CMD_LOAD) && in_range_ld;
  assign tbl_waddr = AW'(32'(q_head.node_index) * EMBED_DIM + 32'(q_head.element_index));
  assign tbl_raddr = AW'(32'(node_r) * EMBED_DIM + 32'(d_r));

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= q_head.table_value;
    tbl_q_r <= tbl_mem[tbl_raddr];
  end

  // accumulate stage, saturating to the accumulator width
  assign acc_sum = (ACC_W+1)'(accb_r) + (ACC_W+1)'(prod_r);
  always_comb begin
    priority if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else acc_sat = acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (p2_v_r) acc_mem[p2_d_r] <= acc_sat;
    acc_q_r  <= acc_mem[d_r];
    accv_q_r <= vld_r[d_r];
    prod_r   <= PROD_W'(wgt_r * tbl_q_r);
    accb_r   <= accv_q_r ? acc_q_r : '0;
  end

  assign wt_sum = (WT_W+1)'(wt_r) + (WT_W+1)'(wgt_r);
  always_comb begin
    priority if (wt_sum[WT_W] != wt_sum[WT_W-1])
      wt_sat = wt_sum[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
    else wt_sat = wt_sum[WT_W-1:0];
  end

  assign acc_cur = accv_q_r ? acc_q_r : '0;
  assign mag = acc_cur[ACC_W-1] ? ACC_W'(-acc_cur) : ACC_W'(acc_cur);
  assign wm  = wt_r[WT_W-1] ? WT_W'(-wt_r) : WT_W'(wt_r);
  assign trial = {rem_r, n_r[DIV_W-1]};
  assign ge = (trial >= {1'b0, den_r});

  // final clip to sixteen bits
  always_comb begin
    if (neg_r) begin
      sat = (q_r > DIV_W'(32768));
      value = sat ? 16'sh8000 : 16'(-q_r[15:0]);
    end else begin
      sat = (q_r > DIV_W'(32767));
      value = sat ? 16'sh7fff : q_r[15:0];
    end
  end

  assign last = (d_r == dim_last);
  assign o_push = (state_r == S_EMIT) && !o_full;
  assign o_data.value = value;
  assign o_data.element = 6'(d_r);
  assign o_data.last_element = last;
  assign o_data.zero_weight_sum = zf_r;
  assign o_data.saturated = sat;

  always_comb begin
    state_nxt = state_r;
    d_nxt = d_r;
    node_nxt = node_r;
    wgt_nxt = wgt_r;
    n_nxt = n_r;
    q_nxt = q_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    zf_nxt = zf_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          node_nxt = q_head.node_index;
          wgt_nxt  = q_head.edge_weight;
          d_nxt    = '0;
          if (q_head.command == CMD_SPARSE && in_range_sp) state_nxt = S_SPARSE;
          else if (q_head.command == CMD_ROW_END) state_nxt = S_RD;
        end
      end
      S_SPARSE: begin
        if (last) state_nxt = S_DRAIN;
        else d_nxt = d_r + 1'b1;
      end
      S_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = S_IDLE;
      end
      S_RD: state_nxt = S_CALC;
      S_CALC: begin
        if (!mean_mode) begin
          q_nxt = DIV_W'(((ACC_W+1)'(mag) + RND) >> FRAC_BITS);
          neg_nxt = acc_cur[ACC_W-1];
          zf_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else if (wt_r == '0) begin
          q_nxt = '0;
          neg_nxt = 1'b0;
          zf_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          n_nxt = {1'b0, mag, 1'b0} + DIV_W'(wm);
          den_nxt = {wm, 1'b0};
          rem_nxt = '0;
          q_nxt = '0;
          cnt_nxt = 6'(DIV_W);
          neg_nxt = acc_cur[ACC_W-1] ^ wt_r[WT_W-1];
          zf_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit a cycle, restoring
        rem_nxt = ge ? (WT_W+1)'(trial - {1'b0, den_r}) : trial[WT_W:0];
        n_nxt = {n_r[DIV_W-2:0], 1'b0};
        q_nxt = {q_r[DIV_W-2:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (o_push) begin
          if (last) state_nxt = S_IDLE;
          else begin
            d_nxt = d_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    wgt_r  <= wgt_nxt;
    n_r    <= n_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    zf_r   <= zf_nxt;
    p1_d_r <= d_r;
    p2_d_r <= p1_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      d_r     <= '0;
      cnt_r   <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      vld_r   <= '0;
      wt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
      cnt_r   <= cnt_nxt;
      p1_v_r  <= (state_r == S_SPARSE);
      p2_v_r  <= p1_v_r;
      if (state_r == S_DRAIN && !p1_v_r && !p2_v_r) wt_r <= wt_sat;
      if (o_push && last) begin
        vld_r <= '0;
        wt_r  <= '0;
      end else if (p2_v_r) begin
        vld_r[p2_d_r] <= 1'b1;
      end
    end
  end

  a_div_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (cnt_nxt == cnt_r || state_r == S_CALC))
    else $error("divider count moved outside a division");
  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && last) |=> (vld_r == '0 && wt_r == '0))
    else $error("row state not cleared after final element");
  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RD) |-> (!p1_v_r && !p2_v_r))
    else $error("accumulate pipeline busy outside a sparse entry");

endmodule

[design/sparse_row_embedding_aggregate.sv]
// sparse_row_embedding_aggregate: top level, configuration registers and wiring
// front queue, execution engine and result queue
// depends on srea_pkg, srea_front, srea_back, srea_ofifo
//
// Use: requests are pushed on in_* (push while full is low). A load request
// writes one table element when its indexes are in range. A sparse entry
// walks the active row elements through a three-stage multiply-accumulate
// on the table and accumulator memories. A row end produces one result per
// active element on out_*; in mean mode a bit-serial divider gives one
// quotient bit a cycle. Results wait in a two-entry queue; when the consumer
// does not pop, the engine stops and the four-entry request queue fills,
// then full rises. Configuration is written through cfg_* (always ready);
// the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears the queues, accumulator valid flags,
// weight total and registers (sum mode, 64 elements); the table keeps no
// reset value and must be loaded before it is read.
module sparse_row_embedding_aggregate #(
  parameter int TABLE_ROWS = 1024,
  parameter int EMBED_DIM  = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [9:0]         in_node_index,
  input  logic [5:0]         in_element_index,
  input  logic signed [15:0] in_table_value,
  input  logic signed [15:0] in_edge_weight,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_value,
  output logic [5:0]         out_element,
  output logic               out_last_element,
  output logic               out_zero_weight_sum,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import srea_pkg::*;

  item_t   in_item, q_head;
  result_t o_data, o_head;
  logic    q_empty, q_pop, o_full, o_push;
  logic    mean_mode_r;
  logic [6:0] active_dim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_mode_r  <= 1'b0;
      active_dim_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MEAN_MODE) mean_mode_r <= cfg_data[0];
      else if (cfg_index == CFG_ACTIVE_DIM) active_dim_r <= cfg_data;
    end
  end

  assign in_item.command       = in_command;
  assign in_item.node_index    = in_node_index;
  assign in_item.element_index = in_element_index;
  assign in_item.table_value   = in_table_value;
  assign in_item.edge_weight   = in_edge_weight;

  srea_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .q_empty(q_empty), .q_pop(q_pop), .q_head(q_head)
  );

  srea_back #(
    .TABLE_ROWS(TABLE_ROWS), .EMBED_DIM(EMBED_DIM), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .mean_mode(mean_mode_r), .active_dim(active_dim_r),
    .o_full(o_full), .o_push(o_push), .o_data(o_data)
  );

  srea_ofifo u_ofifo (
    .clk(clk), .rst_n(rst_n), .push(o_push), .full(o_full), .din(o_data),
    .empty(out_empty), .pop(out_pop), .dout(o_head)
  );

  assign out_value           = o_head.value;
  assign out_element         = o_head.element;
  assign out_last_element    = o_head.last_element;
  assign out_zero_weight_sum = o_head.zero_weight_sum;
  assign out_saturated       = o_head.saturated;

endmodule
